// File: hdl/graph_depth_first_walker_assert.svh
// Assertion macros shared by the depth-first walker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GRAPH_DEPTH_FIRST_WALKER_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_WALKER_ASSERT_SVH

// condition holds at every edge outside reset
`define DFW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DFW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dfw_pkg.sv
// Shared types and codes of the depth-first walker.
// No dependencies; used by every module of the block but the RAM.
package dfw_pkg;

    localparam int DFW_MAX_VERTICES = 256;
    localparam int DFW_MAX_ENTRIES  = 2048;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [2:0] EV_ADDED = 3'd0;
    localparam logic [2:0] EV_VISIT = 3'd1;
    localparam logic [2:0] EV_EDGE  = 3'd2;
    localparam logic [2:0] EV_DONE  = 3'd3;
    localparam logic [2:0] EV_FULL  = 3'd4;
    localparam logic [2:0] EV_BUSY  = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPEND,
        ST_LINK,
        ST_VISIT,
        ST_POP,
        ST_EDGE,
        ST_SEEN
    } t_state;

    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        logic       strobe;
        logic [2:0] event_res;
        logic [7:0] vertex;
        logic [7:0] child;
        logic       child_seen;
    } t_emit;

endpackage

// File: hdl/dfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dfw_alu.sv
// Shared increment/decrement unit for counters, stack depth and sweep index.
// Depends on dfw_pkg.
module dfw_alu #(
    parameter int WIDTH = 12
) (
    input  dfw_pkg::t_alu_op  i_op,
    input  logic [WIDTH-1:0]  i_operand,
    output logic [WIDTH-1:0]  o_result
);

    import dfw_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_INC: o_result = i_operand + WIDTH'(1);
            ALU_DEC: o_result = i_operand - WIDTH'(1);
        endcase
    end

endmodule

// File: hdl/dfw_seq.sv
// Sequencer of the depth-first walker: command decode, list append, walk steps.
// Depends on dfw_pkg and graph_depth_first_walker_assert.svh; drives the RAMs and ALU.
`include "graph_depth_first_walker_assert.svh"

module dfw_seq #(
    parameter int MAX_VERTICES = dfw_pkg::DFW_MAX_VERTICES,
    parameter int MAX_ENTRIES  = dfw_pkg::DFW_MAX_ENTRIES,
    parameter int VW  = $clog2(MAX_VERTICES),
    parameter int SW  = $clog2(MAX_VERTICES + 1),
    parameter int EAW = $clog2(MAX_ENTRIES),
    parameter int EW  = $clog2(MAX_ENTRIES + 1),
    parameter int AL  = (EW > SW) ? EW : SW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_first_vertex,
    input  logic [7:0]        i_second_vertex,
    output dfw_pkg::t_emit    o_emit,
    output dfw_pkg::t_alu_op  o_alu_op,
    output logic [AL-1:0]     o_alu_operand,
    input  logic [AL-1:0]     i_alu_result,
    output logic [VW-1:0]     o_vtx_waddr,
    output logic [VW-1:0]     o_vtx_raddr,
    output logic              o_head_we,
    output logic [EW-1:0]     o_head_wdata,
    input  logic [EW-1:0]     i_head_rdata,
    output logic              o_tail_we,
    output logic [EAW-1:0]    o_tail_wdata,
    input  logic [EAW-1:0]    i_tail_rdata,
    output logic              o_vis_we,
    output logic              o_vis_wdata,
    input  logic              i_vis_rdata,
    output logic [EAW-1:0]    o_ent_waddr,
    output logic [EAW-1:0]    o_ent_raddr,
    output logic              o_tgt_we,
    output logic [VW-1:0]     o_tgt_wdata,
    input  logic [VW-1:0]     i_tgt_rdata,
    output logic              o_link_we,
    output logic [EW-1:0]     o_link_wdata,
    input  logic [EW-1:0]     i_link_rdata,
    output logic              o_stk_we,
    output logic [VW-1:0]     o_stk_waddr,
    output logic [VW+EW-1:0]  o_stk_wdata,
    output logic [VW-1:0]     o_stk_raddr,
    input  logic [VW+EW-1:0]  i_stk_rdata
);

    import dfw_pkg::*;

    localparam logic [EW-1:0] LINK_NULL   = EW'(MAX_ENTRIES);
    localparam logic [EW-1:0] FULL_AT     = EW'(MAX_ENTRIES - 1);
    localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);
    localparam logic [SW-1:0] STACK_MAX   = SW'(MAX_VERTICES);

    function automatic logic [VW-1:0] fold_vertex(input logic [7:0] x);
        logic [23:0] rem;
        rem = {16'b0, x};
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (24'(MAX_VERTICES) << k)) begin
                rem = rem - (24'(MAX_VERTICES) << k);
            end
        end
        return VW'(rem);
    endfunction

    t_state          r_state, n_state;
    logic            r_init, n_init;
    logic [VW-1:0]   r_sweep, n_sweep;
    logic            r_side, n_side;
    logic [VW-1:0]   r_a, n_a;
    logic [VW-1:0]   r_b, n_b;
    logic            r_fix, n_fix;
    logic [EAW-1:0]  r_fix_addr, n_fix_addr;
    logic [EW-1:0]   r_entry_count, n_entry_count;
    logic [SW-1:0]   r_depth, n_depth;
    logic            r_pending_valid, n_pending_valid;
    logic [VW-1:0]   r_pending_vertex, n_pending_vertex;
    logic            r_walk_active, n_walk_active;
    logic [VW-1:0]   r_top_vertex, n_top_vertex;
    logic [EW-1:0]   r_top_cursor, n_top_cursor;
    logic [VW-1:0]   r_kid, n_kid;

    logic            accept;
    logic [VW-1:0]   fa;
    logic [VW-1:0]   fb;
    logic [VW-1:0]   from_v;
    logic [VW-1:0]   to_v;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign fa     = fold_vertex(i_first_vertex);
    assign fb     = fold_vertex(i_second_vertex);
    assign from_v = r_side ? r_b : r_a;
    assign to_v   = r_side ? r_a : r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_init          <= 1'b1;
            r_sweep         <= '0;
            r_entry_count   <= '0;
            r_depth         <= '0;
            r_pending_valid <= 1'b0;
            r_pending_vertex <= '0;
            r_walk_active   <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_init          <= n_init;
            r_sweep         <= n_sweep;
            r_entry_count   <= n_entry_count;
            r_depth         <= n_depth;
            r_pending_valid <= n_pending_valid;
            r_pending_vertex <= n_pending_vertex;
            r_walk_active   <= n_walk_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side       <= n_side;
        r_a          <= n_a;
        r_b          <= n_b;
        r_fix        <= n_fix;
        r_fix_addr   <= n_fix_addr;
        r_top_vertex <= n_top_vertex;
        r_top_cursor <= n_top_cursor;
        r_kid        <= n_kid;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_sweep == LAST_VERTEX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_ADD: begin
                            if (!r_walk_active && (r_entry_count < FULL_AT)) begin
                                n_state = ST_APPEND;
                            end
                        end
                        CMD_START: n_state = ST_CLEAR;
                        CMD_STEP: begin
                            if (r_walk_active) begin
                                if (r_pending_valid) begin
                                    n_state = ST_VISIT;
                                end else if (r_depth != '0) begin
                                    n_state = (r_top_cursor == LINK_NULL) ? ST_POP : ST_EDGE;
                                end
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_APPEND: n_state = ST_LINK;
            ST_LINK:   n_state = r_side ? ST_IDLE : ST_APPEND;
            ST_VISIT:  n_state = ST_IDLE;
            ST_POP:    n_state = ST_IDLE;
            ST_EDGE:   n_state = ST_SEEN;
            ST_SEEN:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_init           = r_init;
        n_sweep          = r_sweep;
        n_side           = r_side;
        n_a              = r_a;
        n_b              = r_b;
        n_fix            = r_fix;
        n_fix_addr       = r_fix_addr;
        n_entry_count    = r_entry_count;
        n_depth          = r_depth;
        n_pending_valid  = r_pending_valid;
        n_pending_vertex = r_pending_vertex;
        n_walk_active    = r_walk_active;
        n_top_vertex     = r_top_vertex;
        n_top_cursor     = r_top_cursor;
        n_kid            = r_kid;

        o_emit        = '0;
        o_alu_op      = ALU_INC;
        o_alu_operand = '0;
        o_vtx_waddr   = '0;
        o_vtx_raddr   = '0;
        o_head_we     = 1'b0;
        o_head_wdata  = LINK_NULL;
        o_tail_we     = 1'b0;
        o_tail_wdata  = '0;
        o_vis_we      = 1'b0;
        o_vis_wdata   = 1'b0;
        o_ent_waddr   = '0;
        o_ent_raddr   = r_top_cursor[EAW-1:0];
        o_tgt_we      = 1'b0;
        o_tgt_wdata   = '0;
        o_link_we     = 1'b0;
        o_link_wdata  = LINK_NULL;
        o_stk_we      = 1'b0;
        o_stk_waddr   = '0;
        o_stk_wdata   = {r_top_vertex, r_top_cursor};
        o_stk_raddr   = '0;

        unique case (r_state)
            ST_CLEAR: begin
                o_vtx_waddr   = r_sweep;
                o_vis_we      = 1'b1;
                o_head_we     = r_init;
                o_alu_op      = ALU_INC;
                o_alu_operand = AL'(r_sweep);
                n_sweep       = VW'(i_alu_result);
                if (r_sweep == LAST_VERTEX) begin
                    n_sweep = '0;
                    n_init  = 1'b0;
                end
            end
            ST_IDLE: begin
                o_vtx_raddr   = (i_cmd == CMD_ADD) ? fa : r_pending_vertex;
                o_alu_op      = ALU_DEC;
                o_alu_operand = AL'(r_depth);
                o_stk_raddr   = VW'(i_alu_result);
                if (accept) begin
                    unique case (i_cmd)
                        CMD_ADD: begin
                            n_a    = fa;
                            n_b    = fb;
                            n_side = 1'b0;
                            if (r_walk_active) begin
                                o_emit.strobe    = 1'b1;
                                o_emit.event_res = EV_BUSY;
                            end else if (r_entry_count >= FULL_AT) begin
                                o_emit.strobe    = 1'b1;
                                o_emit.event_res = EV_FULL;
                            end
                        end
                        CMD_START: begin
                            n_depth          = '0;
                            n_pending_valid  = 1'b1;
                            n_pending_vertex = fa;
                            n_walk_active    = 1'b1;
                        end
                        CMD_STEP: begin
                            if (!r_walk_active) begin
                                o_emit.strobe    = 1'b1;
                                o_emit.event_res = EV_DONE;
                            end else if (!r_pending_valid && (r_depth == '0)) begin
                                n_walk_active    = 1'b0;
                                o_emit.strobe    = 1'b1;
                                o_emit.event_res = EV_DONE;
                            end
                        end
                        default: n_side = r_side;
                    endcase
                end
            end
            ST_APPEND: begin
                o_ent_waddr  = r_entry_count[EAW-1:0];
                o_tgt_we     = 1'b1;
                o_tgt_wdata  = to_v;
                o_link_we    = 1'b1;
                o_link_wdata = LINK_NULL;
                o_vtx_waddr  = from_v;
                o_tail_we    = 1'b1;
                o_tail_wdata = r_entry_count[EAW-1:0];
                if (i_head_rdata == LINK_NULL) begin
                    o_head_we    = 1'b1;
                    o_head_wdata = r_entry_count;
                    n_fix        = 1'b0;
                end else begin
                    n_fix      = 1'b1;
                    n_fix_addr = i_tail_rdata;
                end
            end
            ST_LINK: begin
                o_ent_waddr   = r_fix_addr;
                o_link_we     = r_fix;
                o_link_wdata  = r_entry_count;
                o_alu_op      = ALU_INC;
                o_alu_operand = AL'(r_entry_count);
                n_entry_count = EW'(i_alu_result);
                o_vtx_raddr   = r_b;
                if (r_side) begin
                    o_emit.strobe    = 1'b1;
                    o_emit.event_res = EV_ADDED;
                end else begin
                    n_side = 1'b1;
                end
            end
            ST_VISIT: begin
                o_vtx_waddr      = r_pending_vertex;
                o_vis_we         = 1'b1;
                o_vis_wdata      = 1'b1;
                n_pending_valid  = 1'b0;
                o_emit.strobe    = 1'b1;
                o_emit.event_res = EV_VISIT;
                o_emit.vertex    = 8'(r_pending_vertex);
                o_alu_op         = ALU_INC;
                o_alu_operand    = AL'(r_depth);
                if (r_depth < STACK_MAX) begin
                    o_stk_we     = (r_depth != '0);
                    o_stk_waddr  = VW'(r_depth);
                    n_top_vertex = r_pending_vertex;
                    n_top_cursor = i_head_rdata;
                    n_depth      = SW'(i_alu_result);
                end
            end
            ST_POP: begin
                o_alu_op      = ALU_DEC;
                o_alu_operand = AL'(r_depth);
                n_depth       = SW'(i_alu_result);
                n_top_vertex  = i_stk_rdata[VW+EW-1:EW];
                n_top_cursor  = i_stk_rdata[EW-1:0];
            end
            ST_EDGE: begin
                n_kid        = i_tgt_rdata;
                n_top_cursor = i_link_rdata;
                o_vtx_raddr  = i_tgt_rdata;
            end
            ST_SEEN: begin
                if (!i_vis_rdata) begin
                    n_pending_valid  = 1'b1;
                    n_pending_vertex = r_kid;
                end
                o_emit.strobe     = 1'b1;
                o_emit.event_res  = EV_EDGE;
                o_emit.vertex     = 8'(r_top_vertex);
                o_emit.child      = 8'(r_kid);
                o_emit.child_seen = i_vis_rdata;
            end
        endcase
    end

    `DFW_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_entry_count <= LINK_NULL, "entry count overflow")
    `DFW_ASSERT_ALWAYS(a_depth_bound, i_clk, i_rst_n, r_depth <= STACK_MAX, "stack depth overflow")
    `DFW_ASSERT_IMPLY(a_pending_walk, i_clk, i_rst_n, r_pending_valid, r_walk_active, "pending vertex outside walk")
    `DFW_ASSERT_IMPLY(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !o_emit.strobe, "item emitted during clear")
    `DFW_ASSERT_NEXT(a_edge_pends, i_clk, i_rst_n, o_emit.strobe && (o_emit.event_res == EV_EDGE) && !o_emit.child_seen, r_pending_valid, "unseen child not pending")

endmodule

// File: hdl/graph_depth_first_walker.sv
// Depth-first walker over an undirected graph held as adjacency lists in RAM.
// An add writes the entry of each direction in the append and link states, or answers busy or full
// from idle; a step answers done from idle, or goes through the visit state, the pop state (a return,
// with no result) or the edge and seen states, which use the registered reads of the list and stack
// RAMs; start sweeps the visited marks, and after reset busy stays high while the list heads and marks
// are swept. A result shows on the o_ ports for one cycle with o_strobe the cycle after the item's
// last cycle; the receiver cannot stall it, so it must take every strobe.
module graph_depth_first_walker #(
    parameter int MAX_VERTICES = dfw_pkg::DFW_MAX_VERTICES,
    parameter int MAX_ENTRIES  = dfw_pkg::DFW_MAX_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_first_vertex,
    input  logic [7:0] i_second_vertex,
    output logic       o_strobe,
    output logic [2:0] o_event_res,
    output logic [7:0] o_vertex,
    output logic [7:0] o_child,
    output logic       o_child_seen
);

    import dfw_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int SW  = $clog2(MAX_VERTICES + 1);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int AL  = (EW > SW) ? EW : SW;

    t_emit           emit;
    logic            r_strobe;
    t_emit           r_emit;
    t_alu_op         alu_op;
    logic [AL-1:0]   alu_operand;
    logic [AL-1:0]   alu_result;
    logic [VW-1:0]   vtx_waddr;
    logic [VW-1:0]   vtx_raddr;
    logic            head_we;
    logic [EW-1:0]   head_wdata;
    logic [EW-1:0]   head_rdata;
    logic            tail_we;
    logic [EAW-1:0]  tail_wdata;
    logic [EAW-1:0]  tail_rdata;
    logic            vis_we;
    logic            vis_wdata;
    logic            vis_rdata;
    logic [EAW-1:0]  ent_waddr;
    logic [EAW-1:0]  ent_raddr;
    logic            tgt_we;
    logic [VW-1:0]   tgt_wdata;
    logic [VW-1:0]   tgt_rdata;
    logic            link_we;
    logic [EW-1:0]   link_wdata;
    logic [EW-1:0]   link_rdata;
    logic            stk_we;
    logic [VW-1:0]   stk_waddr;
    logic [VW+EW-1:0] stk_wdata;
    logic [VW-1:0]   stk_raddr;
    logic [VW+EW-1:0] stk_rdata;

    dfw_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .VW           (VW),
        .SW           (SW),
        .EAW          (EAW),
        .EW           (EW),
        .AL           (AL)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .o_emit          (emit),
        .o_alu_op        (alu_op),
        .o_alu_operand   (alu_operand),
        .i_alu_result    (alu_result),
        .o_vtx_waddr     (vtx_waddr),
        .o_vtx_raddr     (vtx_raddr),
        .o_head_we       (head_we),
        .o_head_wdata    (head_wdata),
        .i_head_rdata    (head_rdata),
        .o_tail_we       (tail_we),
        .o_tail_wdata    (tail_wdata),
        .i_tail_rdata    (tail_rdata),
        .o_vis_we        (vis_we),
        .o_vis_wdata     (vis_wdata),
        .i_vis_rdata     (vis_rdata),
        .o_ent_waddr     (ent_waddr),
        .o_ent_raddr     (ent_raddr),
        .o_tgt_we        (tgt_we),
        .o_tgt_wdata     (tgt_wdata),
        .i_tgt_rdata     (tgt_rdata),
        .o_link_we       (link_we),
        .o_link_wdata    (link_wdata),
        .i_link_rdata    (link_rdata),
        .o_stk_we        (stk_we),
        .o_stk_waddr     (stk_waddr),
        .o_stk_wdata     (stk_wdata),
        .o_stk_raddr     (stk_raddr),
        .i_stk_rdata     (stk_rdata)
    );

    dfw_alu #(.WIDTH(AL)) u_alu (
        .i_op      (alu_op),
        .i_operand (alu_operand),
        .o_result  (alu_result)
    );

    dfw_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (vtx_waddr),
        .i_wdata (head_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (head_rdata)
    );

    dfw_ram #(.WIDTH(EAW), .DEPTH(MAX_VERTICES)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (vtx_waddr),
        .i_wdata (tail_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (tail_rdata)
    );

    dfw_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vtx_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (vis_rdata)
    );

    dfw_ram #(.WIDTH(VW), .DEPTH(MAX_ENTRIES)) u_target_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (ent_waddr),
        .i_wdata (tgt_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (tgt_rdata)
    );

    dfw_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (ent_waddr),
        .i_wdata (link_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (link_rdata)
    );

    dfw_ram #(.WIDTH(VW + EW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit <= emit;
    end

    assign o_strobe     = r_strobe;
    assign o_event_res  = r_emit.event_res;
    assign o_vertex     = r_emit.vertex;
    assign o_child      = r_emit.child;
    assign o_child_seen = r_emit.child_seen;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for graph_depth_first_walker: edge adds, walks, restarts, busy adds.
// Predicts each walk event from its own copy of the lists, marks and stack.
// Depends on dfw_pkg and the graph_depth_first_walker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfw_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int RANDOM_ITEMS  = 560;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] vertex;
        logic [7:0] child;
        logic       child_seen;
    } t_walk_event;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic [1:0] i_cmd           = CMD_NONE;
    logic [7:0] i_first_vertex  = 8'd0;
    logic [7:0] i_second_vertex = 8'd0;
    logic       busy;
    logic       o_strobe;
    logic [2:0] o_event_res;
    logic [7:0] o_vertex;
    logic [7:0] o_child;
    logic       o_child_seen;

    // predicted graph and walk state
    int         adj_head [DFW_MAX_VERTICES] = '{default: DFW_MAX_ENTRIES};
    int         adj_tail [DFW_MAX_VERTICES];
    logic [7:0] adj_to   [DFW_MAX_ENTRIES];
    int         adj_next [DFW_MAX_ENTRIES];
    int         adj_used = 0;
    bit         seen_mark [DFW_MAX_VERTICES];
    logic [7:0] path_vertex [DFW_MAX_VERTICES];
    int         path_cursor [DFW_MAX_VERTICES];
    int         path_depth   = 0;
    bit         visit_due    = 1'b0;
    logic [7:0] visit_vertex = 8'd0;
    bit         walking      = 1'b0;

    t_walk_event expected_events [$];
    int          fail_count  = 0;
    int          items_sent  = 0;
    int          quiet_cycles = 0;
    bit          idle_on     = 1'b0;

    graph_depth_first_walker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .o_strobe        (o_strobe),
        .o_event_res     (o_event_res),
        .o_vertex        (o_vertex),
        .o_child         (o_child),
        .o_child_seen    (o_child_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void link_entry(input logic [7:0] from_v, input logic [7:0] to_v);
        adj_to[adj_used]   = to_v;
        adj_next[adj_used] = DFW_MAX_ENTRIES;
        if (adj_head[from_v] == DFW_MAX_ENTRIES) begin
            adj_head[from_v] = adj_used;
        end else begin
            adj_next[adj_tail[from_v]] = adj_used;
        end
        adj_tail[from_v] = adj_used;
        adj_used++;
    endfunction

    function automatic void predict_walk_event(input logic [1:0] cmd, input logic [7:0] va,
                                               input logic [7:0] vb, output bit fires,
                                               output t_walk_event ev);
        int         cur;
        logic [7:0] kid;
        fires = 1'b0;
        ev    = '0;
        case (cmd)
            CMD_ADD: begin
                fires = 1'b1;
                if (walking) begin
                    ev.event_res = EV_BUSY;
                end else if (DFW_MAX_ENTRIES - adj_used < 2) begin
                    ev.event_res = EV_FULL;
                end else begin
                    link_entry(va, vb);
                    link_entry(vb, va);
                    ev.event_res = EV_ADDED;
                end
            end
            CMD_START: begin
                seen_mark    = '{default: 1'b0};
                path_depth   = 0;
                visit_due    = 1'b1;
                visit_vertex = va;
                walking      = 1'b1;
            end
            CMD_STEP: begin
                fires = 1'b1;
                if (!walking) begin
                    ev.event_res = EV_DONE;
                end else if (visit_due) begin
                    visit_due = 1'b0;
                    seen_mark[visit_vertex] = 1'b1;
                    if (path_depth < DFW_MAX_VERTICES) begin
                        path_vertex[path_depth] = visit_vertex;
                        path_cursor[path_depth] = adj_head[visit_vertex];
                        path_depth++;
                    end
                    ev.event_res = EV_VISIT;
                    ev.vertex    = visit_vertex;
                end else if (path_depth == 0) begin
                    walking      = 1'b0;
                    ev.event_res = EV_DONE;
                end else begin
                    cur = path_cursor[path_depth - 1];
                    if (cur >= DFW_MAX_ENTRIES) begin
                        path_depth--;
                        fires = 1'b0;
                    end else begin
                        kid = adj_to[cur];
                        path_cursor[path_depth - 1] = adj_next[cur];
                        ev.event_res  = EV_EDGE;
                        ev.vertex     = path_vertex[path_depth - 1];
                        ev.child      = kid;
                        ev.child_seen = seen_mark[kid];
                        if (!seen_mark[kid]) begin
                            visit_due    = 1'b1;
                            visit_vertex = kid;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] near_vertex(input logic [7:0] base);
        return base + 8'($urandom_range(0, 7));
    endfunction

    function automatic void report_field(input string field, input int want_v, input int got_v);
        fail_count++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
    endfunction

    task automatic issue_cmd(input logic [1:0] cmd, input logic [7:0] va, input logic [7:0] vb);
        int          gap;
        bit          fires;
        t_walk_event ev;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_first_vertex  <= va;
        i_second_vertex <= vb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_walk_event(cmd, va, vb, fires, ev);
        if (fires) begin
            expected_events = {expected_events, ev};
        end
        items_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic walk_to_end(input bit noisy);
        int pick;
        bit restarted;
        restarted = 1'b0;
        while (walking) begin
            pick = noisy ? $urandom_range(0, 19) : 19;
            if (pick == 0) begin
                issue_cmd(CMD_ADD, 8'($urandom), 8'($urandom));
            end else if (pick == 1) begin
                issue_cmd(CMD_NONE, 8'($urandom), 8'($urandom));
            end else if (pick == 2 && !restarted) begin
                restarted = 1'b1;
                issue_cmd(CMD_START, 8'($urandom), 8'($urandom));
            end else begin
                issue_cmd(CMD_STEP, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_step_without_walk();
        idle_on = 1'b0;
        issue_cmd(CMD_STEP, 8'hFF, 8'h00);
        issue_cmd(CMD_NONE, 8'h00, 8'hFF);
    endtask

    task automatic test_directed_walk();
        issue_cmd(CMD_ADD, 8'h00, 8'hFF);
        issue_cmd(CMD_ADD, 8'hFF, 8'hFF);
        issue_cmd(CMD_ADD, 8'h00, 8'h00);
        issue_cmd(CMD_ADD, 8'h55, 8'hAA);
        issue_cmd(CMD_START, 8'h00, 8'hFF);
        repeat (3) issue_cmd(CMD_STEP, 8'h00, 8'h00);
        issue_cmd(CMD_ADD, 8'h12, 8'h34);
        issue_cmd(CMD_NONE, 8'hFF, 8'hFF);
        walk_to_end(1'b0);
        issue_cmd(CMD_STEP, 8'h00, 8'h00);
        wait_for_results();
        idle_on = 1'b1;
        issue_cmd(CMD_START, 8'hAA, 8'h00);
        repeat (2) issue_cmd(CMD_STEP, 8'hFF, 8'hFF);
        issue_cmd(CMD_START, 8'hFF, 8'h00);
        walk_to_end(1'b0);
    endtask

    task automatic test_random_walks();
        logic [7:0] base;
        int         n_adds;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            base    = 8'($urandom_range(0, 248));
            n_adds  = (adj_used < 1400) ? $urandom_range(0, 6) : 0;
            repeat (n_adds) begin
                if ($urandom_range(0, 7) == 0) begin
                    issue_cmd(CMD_ADD, 8'($urandom), 8'($urandom));
                end else begin
                    issue_cmd(CMD_ADD, near_vertex(base), near_vertex(base));
                end
            end
            if ($urandom_range(0, 5) != 0) begin
                issue_cmd(CMD_START, ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                          near_vertex(base), 8'($urandom));
                walk_to_end(1'b1);
            end
            if ($urandom_range(0, 3) == 0) begin
                issue_cmd(CMD_STEP, 8'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_walk_event want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_events.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result, actual event %0d vertex %0d child %0d seen %0d",
                             $time, o_event_res, o_vertex, o_child, o_child_seen);
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_res !== want.event_res) begin
                        report_field("event_res", want.event_res, o_event_res);
                    end
                    if (o_vertex !== want.vertex) begin
                        report_field("vertex", want.vertex, o_vertex);
                    end
                    if (o_child !== want.child) begin
                        report_field("child", want.child, o_child);
                    end
                    if (o_child_seen !== want.child_seen) begin
                        report_field("child_seen", want.child_seen, o_child_seen);
                    end
                end
            end
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_step_without_walk();
        test_directed_walk();
        wait_for_results();
        test_random_walks();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
